@@ hdl/pesp_pkg.sv @@
`default_nettype none

package pesp_pkg;

   localparam logic [7:0] MAX_BYTES = 8'd255;

   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_END  = 1'b1;

   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_COUNT = 1'b1;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic       cmd;
      logic [7:0] ch;
   } req_type;

   typedef struct packed {
      logic       out_kind;
      logic [7:0] out_value;
      logic       out_last;
      logic       overflow;
   } rsp_type;

   // up to two result beats per item, first slot filled first
   typedef struct packed {
      logic    v0;
      logic    v1;
      rsp_type d0;
      rsp_type d1;
   } push_type;

endpackage

`default_nettype wire

@@ hdl/pesp_core.sv @@
`default_nettype none

module pesp_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire pesp_pkg::req_type item,
   output pesp_pkg::push_type     push
);
   import pesp_pkg::*;

   typedef enum logic [2:0] {
      M_IDLE      = 3'd0,
      M_HEX_START = 3'd1,
      M_HEX       = 3'd2,
      M_DEC_WS    = 3'd3,
      M_DEC_SIGN  = 3'd4,
      M_DEC_DIG   = 3'd5,
      M_DQ        = 3'd6,
      M_SQ        = 3'd7
   } mode_type;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LF     = 8'h66;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UF     = 8'h46;

   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      begin
         r = '0;
         if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, c[3:0]};
         end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
         end
         return r;
      end
   endfunction

   mode_type   mode_ff, mode_in;
   logic [7:0] acc_ff, acc_in;
   logic [1:0] dc_ff, dc_in;
   logic       neg_ff, neg_in;
   logic [7:0] lv_ff, lv_in;
   logic [7:0] bc_ff, bc_in;
   logic       drop_ff, drop_in;

   logic       fl_req;
   logic [7:0] fl_val;
   logic [7:0] fl_lv;
   logic [7:0] dec_val;
   logic [4:0] hx;
   logic       is_dig;
   logic       is_ws;
   logic       fall;
   logic       emit_req;
   logic [7:0] emit_val;
   logic       emit_ok;
   logic [7:0] c;

   assign c       = item.ch;
   assign hx      = hex_decode(c);
   assign is_dig  = (c >= CH_ZERO) && (c <= CH_NINE);
   assign is_ws   = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   assign dec_val = neg_ff ? 8'(8'd0 - acc_ff) : acc_ff;

   // byte held by an open token
   always_comb begin
      fl_req = 1'b0;
      fl_val = acc_ff;
      fl_lv  = lv_ff;
      case (mode_ff)
         M_HEX_START: begin
            fl_req = 1'b1;
            fl_val = lv_ff;
         end
         M_HEX: begin
            fl_req = (dc_ff != 2'd0);
            if (dc_ff != 2'd0) begin
               fl_lv = acc_ff;
            end
         end
         M_DEC_WS, M_DEC_SIGN, M_DEC_DIG: begin
            fl_req = 1'b1;
            fl_val = dec_val;
            fl_lv  = dec_val;
         end
         default: begin
            fl_req = 1'b0;
         end
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      acc_in   = acc_ff;
      dc_in    = dc_ff;
      neg_in   = neg_ff;
      lv_in    = lv_ff;
      fall     = 1'b0;
      emit_req = 1'b0;
      emit_val = c;

      if (item.cmd == CMD_END) begin
         emit_req = fl_req;
         emit_val = fl_val;
      end else begin
         case (mode_ff)
            M_DQ: begin
               if (c == CH_DQUOTE) mode_in = M_IDLE;
               else emit_req = 1'b1;
            end
            M_SQ: begin
               if (c == CH_SQUOTE) mode_in = M_IDLE;
               else emit_req = 1'b1;
            end
            M_HEX_START, M_HEX: begin
               if (hx[4]) begin
                  if (mode_ff == M_HEX_START || dc_ff == 2'd0) begin
                     acc_in  = {4'd0, hx[3:0]};
                     dc_in   = 2'd1;
                     mode_in = M_HEX;
                  end else begin
                     acc_in   = {acc_ff[3:0], hx[3:0]};
                     dc_in    = 2'd0;
                     lv_in    = {acc_ff[3:0], hx[3:0]};
                     emit_req = 1'b1;
                     emit_val = {acc_ff[3:0], hx[3:0]};
                  end
               end else begin
                  fall = 1'b1;
               end
            end
            M_DEC_WS: begin
               if (is_ws) begin
                  mode_in = M_DEC_WS;
               end else if (c == CH_PLUS || c == CH_MINUS) begin
                  neg_in  = (c == CH_MINUS);
                  mode_in = M_DEC_SIGN;
               end else if (is_dig) begin
                  acc_in  = {4'd0, c[3:0]};
                  mode_in = M_DEC_DIG;
               end else begin
                  fall = 1'b1;
               end
            end
            M_DEC_SIGN, M_DEC_DIG: begin
               if (is_dig) begin
                  acc_in  = 8'({acc_ff, 3'd0} + {acc_ff, 1'b0} + {4'd0, c[3:0]});
                  mode_in = M_DEC_DIG;
               end else begin
                  fall = 1'b1;
               end
            end
            default: begin
               fall = 1'b1;
            end
         endcase

         // token closed by this character, which then starts afresh
         if (fall) begin
            emit_req = fl_req;
            emit_val = fl_val;
            lv_in    = fl_lv;
            acc_in   = '0;
            dc_in    = '0;
            neg_in   = 1'b0;
            if (c == CH_DOLLAR)      mode_in = M_HEX_START;
            else if (c == CH_HASH)   mode_in = M_DEC_WS;
            else if (c == CH_DQUOTE) mode_in = M_DQ;
            else if (c == CH_SQUOTE) mode_in = M_SQ;
            else                     mode_in = M_IDLE;
         end
      end
   end

   assign emit_ok = emit_req && (bc_ff < MAX_BYTES);
   assign bc_in   = emit_ok ? 8'(bc_ff + 8'd1) : bc_ff;
   assign drop_in = drop_ff || (emit_req && !emit_ok);

   always_comb begin
      push.v0 = item_valid && (emit_ok || item.cmd == CMD_END);
      push.v1 = item_valid && emit_ok && item.cmd == CMD_END;
      push.d0.out_kind  = KIND_DATA;
      push.d0.out_value = emit_val;
      push.d0.out_last  = 1'b0;
      push.d0.overflow  = 1'b0;
      push.d1.out_kind  = KIND_COUNT;
      push.d1.out_value = bc_in;
      push.d1.out_last  = 1'b1;
      push.d1.overflow  = drop_in;
      if (!emit_ok) begin
         push.d0 = push.d1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         acc_ff  <= '0;
         dc_ff   <= '0;
         neg_ff  <= 1'b0;
         lv_ff   <= '0;
         bc_ff   <= '0;
         drop_ff <= 1'b0;
      end else if (item_valid) begin
         if (item.cmd == CMD_END) begin
            mode_ff <= M_IDLE;
            acc_ff  <= '0;
            dc_ff   <= '0;
            neg_ff  <= 1'b0;
            lv_ff   <= '0;
            bc_ff   <= '0;
            drop_ff <= 1'b0;
         end else begin
            mode_ff <= mode_in;
            acc_ff  <= acc_in;
            dc_ff   <= dc_in;
            neg_ff  <= neg_in;
            lv_ff   <= lv_in;
            bc_ff   <= bc_in;
            drop_ff <= drop_in;
         end
      end
   end

endmodule

`default_nettype wire

@@ hdl/pesp_rsp_fifo.sv @@
`default_nettype none

module pesp_rsp_fifo (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire pesp_pkg::push_type                push,
   input  wire logic                              pop,
   output logic                                   rsp_valid,
   output pesp_pkg::rsp_type                      rsp_data,
   output logic [pesp_pkg::RSP_CNT_W-1:0]         level
);
   import pesp_pkg::*;

   rsp_type                mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ff, wr_in;
   logic [RSP_PTR_W-1:0]   rd_ff, rd_in;
   logic [RSP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [RSP_PTR_W-1:0]   wr_next;
   logic                   do_pop;

   assign do_pop    = pop && (cnt_ff != '0);
   assign wr_next   = RSP_PTR_W'(wr_ff + RSP_PTR_W'(1));
   assign wr_in     = RSP_PTR_W'(wr_ff + RSP_PTR_W'(push.v0) + RSP_PTR_W'(push.v1));
   assign rd_in     = do_pop ? RSP_PTR_W'(rd_ff + RSP_PTR_W'(1)) : rd_ff;
   assign cnt_in    = RSP_CNT_W'(cnt_ff + RSP_CNT_W'(push.v0) + RSP_CNT_W'(push.v1)
                                 - RSP_CNT_W'(do_pop));
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = mem_ff[rd_ff];
   assign level     = cnt_ff;

   always_ff @(posedge clock) begin
      if (push.v0) mem_ff[wr_ff] <= push.d0;
      if (push.v1) mem_ff[wr_next] <= push.d1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/printer_escape_string_parser.sv @@
// Printer escape string parser: send one definition character per beat (cmd 0) and close the
// string with an end beat (cmd 1). Each character beat gives at most one data byte; the end
// beat flushes any pending hex or decimal token and then gives a count record with out_last
// set and overflow telling whether bytes beyond the 255-byte limit were dropped. One item is
// taken every cycle while there is room: a beat is captured in an input register, decoded by
// the parse logic and its results land in a four-entry result queue. The queue lets the input
// run on while results wait; input stalls only when fewer than two queue slots are free, so the
// rate is one item per cycle while rsp_ready keeps up, and set by the rsp side otherwise.
`default_nettype none

module printer_escape_string_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pesp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pesp_pkg::rsp_type      rsp_data
);
   import pesp_pkg::*;

   logic                 stg_valid_ff, stg_valid_in;
   req_type              stg_item_ff;
   logic                 room;
   logic                 advance;
   logic                 process;
   push_type             push;
   logic [RSP_CNT_W-1:0] level;

   assign room         = (level <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign advance      = !stg_valid_ff || room;
   assign process      = stg_valid_ff && room;
   assign req_ready    = advance;
   assign stg_valid_in = advance ? req_valid : stg_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && advance) stg_item_ff <= req_data;
   end

   pesp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (process),
      .item       (stg_item_ff),
      .push       (push)
   );

   pesp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .level     (level)
   );

endmodule

`default_nettype wire

@@ tb/pesp_checker.sv @@
`timescale 1ns / 1ps

module pesp_checker
   import pesp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending
);

   typedef enum logic [2:0] {
      P_IDLE, P_HEX_START, P_HEX, P_DEC_WS, P_DEC_SIGN, P_DEC_DIG, P_DQ, P_SQ
   } parse_state;

   localparam logic [7:0] CH_DOLLAR = "$";
   localparam logic [7:0] CH_HASH   = "#";
   localparam logic [7:0] CH_DQUOTE = "\"";
   localparam logic [7:0] CH_SQUOTE = "'";
   localparam logic [7:0] CH_PLUS   = "+";
   localparam logic [7:0] CH_MINUS  = "-";
   localparam logic [7:0] CH_SPACE  = " ";
   localparam logic [7:0] CH_TAB    = "\t";
   localparam logic [7:0] CH_CR     = "\r";
   localparam logic [7:0] CH_0      = "0";
   localparam logic [7:0] CH_9      = "9";
   localparam logic [7:0] CH_UA     = "A";
   localparam logic [7:0] CH_UF     = "F";
   localparam logic [7:0] CH_LA     = "a";
   localparam logic [7:0] CH_LF     = "f";

   parse_state mode;
   logic [7:0] acc;
   logic [1:0] ndig;
   logic       neg;
   logic [7:0] last_val;
   logic [7:0] nbytes;
   logic       lost;

   rsp_type    byte_q[$];
   rsp_type    want;
   int         errs = 0;

   function automatic int hex_digit(input logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
      if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
      return -1;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_0 && c <= CH_9;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   task automatic clear_parser();
      mode = P_IDLE;
      acc = '0;
      ndig = '0;
      neg = 1'b0;
      last_val = '0;
      nbytes = '0;
      lost = 1'b0;
   endtask

   task automatic push_data(input logic [7:0] v);
      rsp_type r;
      if (nbytes >= MAX_BYTES) begin
         lost = 1'b1;
      end else begin
         r.out_kind = KIND_DATA;
         r.out_value = v;
         r.out_last = 1'b0;
         r.overflow = 1'b0;
         byte_q.push_back(r);
         nbytes = nbytes + 8'd1;
      end
   endtask

   task automatic flush_token();
      case (mode)
         P_HEX_START: push_data(last_val);
         P_HEX: begin
            if (ndig != 0) begin
               last_val = acc;
               push_data(acc);
            end
         end
         P_DEC_WS, P_DEC_SIGN, P_DEC_DIG: begin
            last_val = neg ? 8'(8'd0 - acc) : acc;
            push_data(last_val);
         end
         default: ;
      endcase
   endtask

   task automatic predict(input req_type r);
      rsp_type    cnt;
      int         h;
      logic [7:0] c;
      c = r.ch;
      if (r.cmd == CMD_END) begin
         flush_token();
         cnt.out_kind = KIND_COUNT;
         cnt.out_value = nbytes;
         cnt.out_last = 1'b1;
         cnt.overflow = lost;
         byte_q.push_back(cnt);
         clear_parser();
         return;
      end
      h = hex_digit(c);
      case (mode)
         P_DQ: begin
            if (c == CH_DQUOTE) mode = P_IDLE;
            else push_data(c);
            return;
         end
         P_SQ: begin
            if (c == CH_SQUOTE) mode = P_IDLE;
            else push_data(c);
            return;
         end
         P_HEX_START, P_HEX: begin
            if (h >= 0) begin
               if (mode == P_HEX_START || ndig == 0) begin
                  acc = 8'(h);
                  ndig = 2'd1;
                  mode = P_HEX;
               end else begin
                  acc = {acc[3:0], h[3:0]};
                  ndig = 2'd0;
                  last_val = acc;
                  push_data(acc);
               end
               return;
            end
         end
         P_DEC_WS: begin
            if (is_space(c)) return;
            if (c == CH_PLUS || c == CH_MINUS) begin
               neg = (c == CH_MINUS);
               mode = P_DEC_SIGN;
               return;
            end
            if (is_digit(c)) begin
               acc = c - CH_0;
               mode = P_DEC_DIG;
               return;
            end
         end
         P_DEC_SIGN, P_DEC_DIG: begin
            if (is_digit(c)) begin
               acc = acc * 8'd10 + (c - CH_0);
               mode = P_DEC_DIG;
               return;
            end
         end
         default: ;
      endcase
      // token closed by this character, which then starts fresh
      flush_token();
      mode = P_IDLE;
      acc = '0;
      ndig = '0;
      neg = 1'b0;
      if (c == CH_DOLLAR) mode = P_HEX_START;
      else if (c == CH_HASH) mode = P_DEC_WS;
      else if (c == CH_DQUOTE) mode = P_DQ;
      else if (c == CH_SQUOTE) mode = P_SQ;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         byte_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (byte_q.size() == 0) begin
               $error("unexpected beat: kind %0d value %0d", rsp_data.out_kind,
                      rsp_data.out_value);
               errs++;
            end else begin
               want = byte_q.pop_front();
               if (rsp_data.out_kind !== want.out_kind) begin
                  $error("out_kind expected %0d got %0d", want.out_kind, rsp_data.out_kind);
                  errs++;
               end
               if (rsp_data.out_value !== want.out_value) begin
                  $error("out_value expected %0d got %0d", want.out_value,
                         rsp_data.out_value);
                  errs++;
               end
               if (rsp_data.out_last !== want.out_last) begin
                  $error("out_last expected %0d got %0d", want.out_last, rsp_data.out_last);
                  errs++;
               end
               if (rsp_data.overflow !== want.overflow) begin
                  $error("overflow expected %0d got %0d", want.overflow, rsp_data.overflow);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready) predict(req_data);
      end
      pending <= byte_q.size();
      fail_count <= errs;
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import pesp_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_AT     = 300;
   localparam int HOLD_CYCLES = 80;
   localparam int RANDOM_BEATS = 700;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int      fail_count;
   int      pending;
   int      beats = 0;
   logic    quiet = 1'b0;

   printer_escape_string_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   pesp_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic put_beat(input logic cmd, input logic [7:0] c);
      while (!quiet && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{cmd: cmd, ch: c};
      do @(posedge clock); while (!req_ready);
      beats++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) put_beat(CMD_CHAR, s[i]);
   endtask

   function automatic logic [7:0] rand_hex();
      int v;
      v = $urandom_range(15);
      if (v < 10) return 8'("0" + v);
      return $urandom_range(1) ? 8'("A" + v - 10) : 8'("a" + v - 10);
   endfunction

   task automatic send_token();
      int         kind;
      logic [7:0] closer;
      logic [7:0] c;
      kind = $urandom_range(9);
      if (kind <= 2) begin
         put_beat(CMD_CHAR, "$");
         repeat ($urandom_range(5)) put_beat(CMD_CHAR, rand_hex());
      end else if (kind <= 5) begin
         put_beat(CMD_CHAR, "#");
         repeat ($urandom_range(2))
            put_beat(CMD_CHAR, $urandom_range(1) ? 8'(" ") : 8'("\t" + $urandom_range(4)));
         if ($urandom_range(2) > 0) put_beat(CMD_CHAR, $urandom_range(1) ? 8'("-") : 8'("+"));
         repeat ($urandom_range(4)) put_beat(CMD_CHAR, 8'("0" + $urandom_range(9)));
      end else if (kind <= 7) begin
         closer = $urandom_range(1) ? 8'("\"") : 8'("'");
         put_beat(CMD_CHAR, closer);
         repeat ($urandom_range(6)) begin
            do c = 8'($urandom_range(255)); while (c == closer);
            put_beat(CMD_CHAR, c);
         end
         if ($urandom_range(4) > 0) put_beat(CMD_CHAR, closer);
      end else begin
         put_beat(CMD_CHAR, 8'($urandom_range(255)));
      end
   endtask

   // receiver, with one long hold-off so the block backs up
   initial begin
      int cyc;
      cyc = 0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         cyc++;
         if (cyc == HOLD_AT) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= quiet || ($urandom_range(99) >= 31);
            @(posedge clock);
         end
      end
   end

   initial begin
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("printer_escape_string_parser: mismatch");
      $finish;
   end

   initial begin
      int first;
      int nstr;
      int n;
      logic [7:0] c;
      req_valid <= 1'b0;
      req_data <= '0;
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_text("$$1bF");
      put_beat(CMD_END, 8'h00);
      send_text("#\t-259");
      put_beat(CMD_CHAR, 8'h00);
      put_beat(CMD_END, 8'hFF);
      send_text("#+ '\"");
      put_beat(CMD_CHAR, 8'hFF);
      send_text("'\"");
      put_beat(CMD_CHAR, 8'h80);
      put_beat(CMD_END, 8'h5A);

      first = beats;
      nstr = 0;
      while (beats - first < RANDOM_BEATS) begin
         quiet = (nstr >= 12 && nstr < 20);
         if (nstr == 4) begin
            // long quoted run that reaches or passes the byte limit, left open at the end
            put_beat(CMD_CHAR, "\"");
            n = $urandom_range(255, 262);
            repeat (n) begin
               do c = 8'($urandom_range(255)); while (c == "\"");
               put_beat(CMD_CHAR, c);
            end
         end else begin
            repeat ($urandom_range(1, 8)) send_token();
         end
         put_beat(CMD_END, 8'($urandom_range(255)));
         nstr++;
      end
      quiet = 1'b0;

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("printer_escape_string_parser: match");
      else $display("printer_escape_string_parser: mismatch");
      $finish;
   end

endmodule

@@ files.f @@
hdl/pesp_pkg.sv
hdl/pesp_core.sv
hdl/pesp_rsp_fifo.sv
hdl/printer_escape_string_parser.sv
tb/pesp_checker.sv
tb/tb_top.sv
